[hw/rtl/phr_pkg.sv]
package phr_pkg;

    // fixed point fraction bits of hue and sector ratio
    localparam int FRACTION_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_NEW_HUE     = 2'd0;
    localparam logic [1:0] CFG_FIRST_ENTRY = 2'd1;
    localparam logic [1:0] CFG_LAST_ENTRY  = 2'd2;

    // register reset values
    localparam logic [7:0] NEW_HUE_RST     = 8'd30;
    localparam logic [7:0] FIRST_ENTRY_RST = 8'd192;
    localparam logic [7:0] LAST_ENTRY_RST  = 8'd223;

    // what a recolored channel takes
    typedef enum logic [1:0] {
        ROLE_LO,
        ROLE_HI,
        ROLE_MIX
    } role_t;

    // hue and ratio precompute sequencer
    typedef enum logic [2:0] {
        HS_START_HUE,
        HS_HUE_FRAC,
        HS_SECTOR,
        HS_DIV_RATIO,
        HS_IDLE
    } hue_state_t;

    // settings handed from the control side to the datapath
    typedef struct packed {
        logic [7:0] first_entry;
        logic [7:0] last_entry;
        role_t      red_role;
        role_t      green_role;
        role_t      blue_role;
    } settings_t;

endpackage

[hw/rtl/phr_div.sv]
module phr_div #(
    parameter int DW = 41,
    parameter int VW = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] quo_next;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] rem_next;
    logic [VW-1:0] divisor_reg;
    logic [VW:0]   rem_shift;
    logic [VW+1:0] trial;

    // one restoring step per cycle, quotient shifts in as dividend shifts out
    always_comb
    begin
        rem_shift  = {rem_reg, quo_reg[DW-1]};
        trial      = {1'b0, rem_shift} - {2'b00, divisor_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            quo_next   = dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            if (trial[VW+1])
            begin
                rem_next = rem_shift[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            count_next = count_reg + 1'b1;
            if (count_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/phr_hue.sv]
module phr_hue #(
    parameter int FRACTION_BITS = phr_pkg::FRACTION_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [7:0]              cfg_data,
    output phr_pkg::settings_t      settings,
    output logic [FRACTION_BITS:0]  ratio,
    output logic                    busy
);

    localparam int HW = FRACTION_BITS + 9;
    localparam int DW = 2 * FRACTION_BITS + 9;
    localparam int RW = FRACTION_BITS + 1;

    localparam logic [HW-1:0] DEG60  = HW'(60) << FRACTION_BITS;
    localparam logic [HW-1:0] DEG120 = HW'(120) << FRACTION_BITS;
    localparam logic [HW-1:0] DEG180 = HW'(180) << FRACTION_BITS;
    localparam logic [HW-1:0] DEG240 = HW'(240) << FRACTION_BITS;
    localparam logic [HW-1:0] DEG300 = HW'(300) << FRACTION_BITS;
    localparam logic [HW-1:0] DEG360 = HW'(360) << FRACTION_BITS;
    localparam logic [RW-1:0] RATIO_ONE   = RW'(1) << FRACTION_BITS;

    // 360 * ceil(2^25 / 255): exact floor(new_hue * 360 / 255) for every 8-bit hue
    localparam logic [33:0] HUE_RECIP       = 34'd47371320;
    localparam int          HUE_RECIP_SHIFT = 25;

    phr_pkg::hue_state_t state_reg;
    phr_pkg::hue_state_t state_next;

    logic [7:0]    new_hue_reg;
    logic [7:0]    first_entry_reg;
    logic [7:0]    last_entry_reg;
    logic [8:0]    hue_whole_reg;
    logic [HW-1:0] h_reg;
    logic [RW-1:0] ratio_reg;
    logic          den_zero_reg;
    phr_pkg::role_t red_role_reg;
    phr_pkg::role_t green_role_reg;
    phr_pkg::role_t blue_role_reg;

    logic [8:0]    hue_whole;
    logic [7:0]    hue_low;
    logic [7:0]    hue_rem;
    logic [31:0]   hue_rep;
    logic [HW-1:0] h_next;
    logic [HW-1:0] num;
    logic [HW-1:0] den;
    phr_pkg::role_t red_role;
    phr_pkg::role_t green_role;
    phr_pkg::role_t blue_role;

    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [HW-1:0] div_divisor;
    logic          div_done;
    logic [DW-1:0] div_quotient;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_hue_reg     <= phr_pkg::NEW_HUE_RST;
            first_entry_reg <= phr_pkg::FIRST_ENTRY_RST;
            last_entry_reg  <= phr_pkg::LAST_ENTRY_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                phr_pkg::CFG_NEW_HUE:     new_hue_reg     <= cfg_data;
                phr_pkg::CFG_FIRST_ENTRY: first_entry_reg <= cfg_data;
                phr_pkg::CFG_LAST_ENTRY:  last_entry_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // whole degrees by reciprocal multiply
    assign hue_whole = 9'((34'(new_hue_reg) * HUE_RECIP) >> HUE_RECIP_SHIFT);
    assign hue_low   = 8'(17'(new_hue_reg) * 17'd360);
    // x - 255*q equals x + q modulo 256, and the remainder stays below 255
    assign hue_rem   = hue_low + hue_whole_reg[7:0];
    // rem/255 in binary is the byte rem repeated
    assign hue_rep   = {4{hue_rem}};
    assign h_next    = (HW'(hue_whole_reg) << FRACTION_BITS)
                     + HW'(hue_rep >> (32 - FRACTION_BITS));

    // sector selection from the hue in degrees
    always_comb
    begin
        if (h_reg <= DEG120)
        begin
            blue_role = phr_pkg::ROLE_LO;
            if (h_reg < DEG60)
            begin
                red_role   = phr_pkg::ROLE_HI;
                green_role = phr_pkg::ROLE_MIX;
                num        = h_reg;
                den        = DEG120 - h_reg;
            end
            else
            begin
                green_role = phr_pkg::ROLE_HI;
                red_role   = phr_pkg::ROLE_MIX;
                num        = DEG120 - h_reg;
                den        = h_reg;
            end
        end
        else if (h_reg <= DEG240)
        begin
            red_role = phr_pkg::ROLE_LO;
            if (h_reg < DEG180)
            begin
                green_role = phr_pkg::ROLE_HI;
                blue_role  = phr_pkg::ROLE_MIX;
                num        = h_reg - DEG120;
                den        = DEG240 - h_reg;
            end
            else
            begin
                blue_role  = phr_pkg::ROLE_HI;
                green_role = phr_pkg::ROLE_MIX;
                num        = DEG240 - h_reg;
                den        = h_reg - DEG120;
            end
        end
        else
        begin
            green_role = phr_pkg::ROLE_LO;
            if (h_reg < DEG300)
            begin
                blue_role = phr_pkg::ROLE_HI;
                red_role  = phr_pkg::ROLE_MIX;
                num       = h_reg - DEG240;
                den       = DEG360 - h_reg;
            end
            else
            begin
                red_role  = phr_pkg::ROLE_HI;
                blue_role = phr_pkg::ROLE_MIX;
                num       = DEG360 - h_reg;
                den       = h_reg - DEG240;
            end
        end
    end

    // sequencer: whole degrees, fraction bits, sector roles, then ratio = num/den on the divider
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = {num, {FRACTION_BITS{1'b0}}};
        div_divisor  = den;
        case (state_reg)
            phr_pkg::HS_START_HUE:
            begin
                state_next = phr_pkg::HS_HUE_FRAC;
            end
            phr_pkg::HS_HUE_FRAC:
            begin
                state_next = phr_pkg::HS_SECTOR;
            end
            phr_pkg::HS_SECTOR:
            begin
                div_start  = 1'b1;
                state_next = phr_pkg::HS_DIV_RATIO;
            end
            phr_pkg::HS_DIV_RATIO:
            begin
                if (div_done)
                begin
                    state_next = phr_pkg::HS_IDLE;
                end
            end
            phr_pkg::HS_IDLE:
            begin
                state_next = phr_pkg::HS_IDLE;
            end
            default:
            begin
                state_next = phr_pkg::HS_START_HUE;
            end
        endcase
        // a hue write restarts the precompute
        if (cfg_write && cfg_index == phr_pkg::CFG_NEW_HUE)
        begin
            state_next = phr_pkg::HS_START_HUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= phr_pkg::HS_START_HUE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == phr_pkg::HS_START_HUE)
        begin
            hue_whole_reg <= hue_whole;
        end
        if (state_reg == phr_pkg::HS_HUE_FRAC)
        begin
            h_reg <= h_next;
        end
        if (state_reg == phr_pkg::HS_SECTOR)
        begin
            red_role_reg   <= red_role;
            green_role_reg <= green_role;
            blue_role_reg  <= blue_role;
            den_zero_reg   <= (den == '0);
        end
        if (state_reg == phr_pkg::HS_DIV_RATIO && div_done)
        begin
            // zero denominator guard: blend falls back to the floor
            ratio_reg <= den_zero_reg ? '0 : div_quotient[RW-1:0];
        end
    end

    phr_div #(
        .DW (DW),
        .VW (HW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign settings.first_entry = first_entry_reg;
    assign settings.last_entry  = last_entry_reg;
    assign settings.red_role    = red_role_reg;
    assign settings.green_role  = green_role_reg;
    assign settings.blue_role   = blue_role_reg;
    assign ratio                = ratio_reg;
    assign busy                 = (state_reg != phr_pkg::HS_IDLE);

    // sector ratios never exceed one
    a_ratio_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == phr_pkg::HS_IDLE) |-> (ratio_reg <= RATIO_ONE))
        else $error("sector ratio above one");

    // the ratio is only taken after the division completes
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(state_reg == phr_pkg::HS_IDLE)) |-> $past(div_done))
        else $error("precompute finished without divider done");

endmodule

[hw/rtl/phr_pipe.sv]
module phr_pipe #(
    parameter int FRACTION_BITS = phr_pkg::FRACTION_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   hold,
    input  phr_pkg::settings_t     settings,
    input  logic [FRACTION_BITS:0] ratio,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             entry_index,
    input  logic [7:0]             red_in,
    input  logic [7:0]             green_in,
    input  logic [7:0]             blue_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             red_out,
    output logic [7:0]             green_out,
    output logic [7:0]             blue_out,
    output logic                   recoloured
);

    localparam int PW = FRACTION_BITS + 9;

    // stage 1: range check, max and min
    logic       s1_valid_reg;
    logic       s1_rec_reg;
    logic [7:0] s1_r_reg;
    logic [7:0] s1_g_reg;
    logic [7:0] s1_b_reg;
    logic [7:0] s1_hi_reg;
    logic [7:0] s1_lo_reg;
    // stage 2: span times ratio
    logic          s2_valid_reg;
    logic          s2_rec_reg;
    logic [7:0]    s2_r_reg;
    logic [7:0]    s2_g_reg;
    logic [7:0]    s2_b_reg;
    logic [7:0]    s2_hi_reg;
    logic [7:0]    s2_lo_reg;
    logic [PW-1:0] s2_prod_reg;
    // stage 3: output register
    logic       s3_valid_reg;
    logic       s3_rec_reg;
    logic [7:0] s3_r_reg;
    logic [7:0] s3_g_reg;
    logic [7:0] s3_b_reg;

    logic       ready1;
    logic       ready2;
    logic       ready3;
    logic       in_range;
    logic [7:0] max_rg;
    logic [7:0] min_rg;
    logic [7:0] hi_next;
    logic [7:0] lo_next;
    logic [7:0] span;
    logic [PW-1:0] prod_next;
    logic [7:0] mix;
    logic [7:0] r_next;
    logic [7:0] g_next;
    logic [7:0] b_next;

    assign ready3   = !s3_valid_reg || out_ready;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign in_ready = ready1 && !hold;

    assign in_range = (entry_index >= settings.first_entry)
                   && (entry_index <= settings.last_entry);
    assign max_rg   = (red_in > green_in) ? red_in : green_in;
    assign min_rg   = (red_in < green_in) ? red_in : green_in;
    assign hi_next  = (blue_in > max_rg) ? blue_in : max_rg;
    assign lo_next  = (blue_in < min_rg) ? blue_in : min_rg;

    assign span      = s1_hi_reg - s1_lo_reg;
    assign prod_next = PW'(ratio) * PW'(span);

    assign mix = s2_lo_reg + s2_prod_reg[FRACTION_BITS +: 8];

    function automatic logic [7:0] pick(input phr_pkg::role_t role, input logic [7:0] lo,
                                        input logic [7:0] hi, input logic [7:0] mid);
        logic [7:0] value;
        case (role)
            phr_pkg::ROLE_LO:  value = lo;
            phr_pkg::ROLE_HI:  value = hi;
            phr_pkg::ROLE_MIX: value = mid;
            default:           value = lo;
        endcase
        return value;
    endfunction

    always_comb
    begin
        if (s2_rec_reg)
        begin
            r_next = pick(settings.red_role, s2_lo_reg, s2_hi_reg, mix);
            g_next = pick(settings.green_role, s2_lo_reg, s2_hi_reg, mix);
            b_next = pick(settings.blue_role, s2_lo_reg, s2_hi_reg, mix);
        end
        else
        begin
            r_next = s2_r_reg;
            g_next = s2_g_reg;
            b_next = s2_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= in_valid && !hold;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            s1_rec_reg <= in_range;
            s1_r_reg   <= red_in;
            s1_g_reg   <= green_in;
            s1_b_reg   <= blue_in;
            s1_hi_reg  <= hi_next;
            s1_lo_reg  <= lo_next;
        end
        if (ready2)
        begin
            s2_rec_reg  <= s1_rec_reg;
            s2_r_reg    <= s1_r_reg;
            s2_g_reg    <= s1_g_reg;
            s2_b_reg    <= s1_b_reg;
            s2_hi_reg   <= s1_hi_reg;
            s2_lo_reg   <= s1_lo_reg;
            s2_prod_reg <= prod_next;
        end
        if (ready3)
        begin
            s3_rec_reg <= s2_rec_reg;
            s3_r_reg   <= r_next;
            s3_g_reg   <= g_next;
            s3_b_reg   <= b_next;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign red_out    = s3_r_reg;
    assign green_out  = s3_g_reg;
    assign blue_out   = s3_b_reg;
    assign recoloured = s3_rec_reg;

    a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted request not in stage 1");

    a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && ready2) |=> s2_valid_reg)
        else $error("stage 1 request lost");

    a_blend_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_rec_reg)
            |-> ({1'b0, s2_prod_reg[FRACTION_BITS +: 8]} <= {1'b0, s2_hi_reg - s2_lo_reg}))
        else $error("blend exceeds value");

endmodule

[hw/rtl/palette_hue_replace.sv]
// palette_hue_replace: per-entry hue replacement over an index range
// s_axis entries reach m_axis_tvalid through the three pipeline registers
// throughput: one entry per cycle unless m_axis_tready stalls, no state between entries
// reset and every new_hue write: s_axis_tready stays low while the hue precompute runs:
// two hue steps, sector pick, then the serial ratio divider
// reset clears valid bits and loads new_hue 30, first_entry 192, last_entry 223
module palette_hue_replace #(
    parameter int FRACTION_BITS = phr_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input entries
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // entry_index, red_in, green_in, blue_in
    // result entries
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic [0:0]  m_axis_tuser,   // recoloured
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    phr_pkg::settings_t     settings;
    logic [FRACTION_BITS:0] ratio;
    logic                   busy;
    logic                   cfg_write;
    logic [7:0]             red_out;
    logic [7:0]             green_out;
    logic [7:0]             blue_out;
    logic                   recoloured;

    // register writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    // hue, sector roles and ratio only depend on the registers, so they are
    // computed once per hue change instead of per entry
    phr_hue #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_hue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .settings  (settings),
        .ratio     (ratio),
        .busy      (busy)
    );

    // per-entry pipeline: range and max/min, span multiply, blend and select
    phr_pipe #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .hold        (busy),
        .settings    (settings),
        .ratio       (ratio),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .entry_index (s_axis_tdata[7:0]),
        .red_in      (s_axis_tdata[15:8]),
        .green_in    (s_axis_tdata[23:16]),
        .blue_in     (s_axis_tdata[31:24]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .recoloured  (recoloured)
    );

    assign m_axis_tdata = {blue_out, green_out, red_out};
    assign m_axis_tuser = recoloured;

endmodule
